@@ rtl/core/arp_cache_resolver_macros.svh @@
// ----------------------------------------------------------------------------
// ARP cache resolver assertion macros
// Shorthand for clocked assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_RESOLVER_MACROS_SVH
`define ARP_CACHE_RESOLVER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ARPC_ASSERT_HOLDS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ARPC_ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);
`else
`define ARPC_ASSERT_HOLDS(label, clk, rst, cond, msg)
`define ARPC_ASSERT_NEXT(label, clk, rst, cause, effect, msg)
`endif
`endif

@@ rtl/core/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP cache resolver package
// Shared sizes, codes and beat types.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int CACHE_DEPTH   = 32;
  localparam int PENDING_DEPTH = 16;
  localparam int PORT_BITS     = 4;

  localparam int CIDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int PIDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  localparam int APB_ADDR_W = 4;

  localparam logic [1:0] REG_ENTRY_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_RESEND        = 2'd1;
  localparam logic [1:0] REG_MAX_ATTEMPTS  = 2'd2;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_REPLY  = 2'd1;
  localparam logic [1:0] OP_QUEUE  = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [2:0] KIND_LOOKUP      = 3'd0;
  localparam logic [2:0] KIND_SEND_REQ    = 3'd1;
  localparam logic [2:0] KIND_FLUSH       = 3'd2;
  localparam logic [2:0] KIND_IGNORED     = 3'd3;
  localparam logic [2:0] KIND_QUEUED      = 3'd4;
  localparam logic [2:0] KIND_UNREACHABLE = 3'd5;
  localparam logic [2:0] KIND_PEND_FULL   = 3'd6;
  localparam logic [2:0] KIND_TICK_DONE   = 3'd7;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] ip_address;
    logic [47:0] hw_address;
    logic [3:0]  port;
  } req_beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        hit;
    logic [31:0] out_ip;
    logic [47:0] out_mac;
    logic [3:0]  out_port;
    logic        last;
  } rsp_beat_t;

  typedef struct packed {
    logic [30:0] entry_timeout_ticks;
    logic [30:0] resend_interval_ticks;
    logic [3:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } cache_entry_t;

  typedef struct packed {
    logic [31:0]          ip;
    logic [PORT_BITS-1:0] port;
    logic [3:0]           attempts;
    logic [31:0]          stamp;
  } pend_entry_t;

endpackage

@@ rtl/core/arpc_ram.sv @@
// ----------------------------------------------------------------------------
// ARP cache resolver RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/arpc_regs.sv @@
// ----------------------------------------------------------------------------
// ARP cache resolver configuration registers
// APB register file for the timeout, resend interval and attempt limit.
// ----------------------------------------------------------------------------
module arpc_regs import arpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output cfg_t                  cfg
);

  logic [1:0] reg_index;

  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_timeout_ticks   <= 31'd15000;
      cfg.resend_interval_ticks <= 31'd1000;
      cfg.max_attempts          <= 4'd7;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        REG_ENTRY_TIMEOUT: cfg.entry_timeout_ticks   <= pwdata[30:0];
        REG_RESEND:        cfg.resend_interval_ticks <= pwdata[30:0];
        REG_MAX_ATTEMPTS:  cfg.max_attempts          <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_ENTRY_TIMEOUT: prdata = {1'b0, cfg.entry_timeout_ticks};
      REG_RESEND:        prdata = {1'b0, cfg.resend_interval_ticks};
      REG_MAX_ATTEMPTS:  prdata = {28'd0, cfg.max_attempts};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/core/arp_cache_resolver.sv @@
// ----------------------------------------------------------------------------
// ARP cache resolver
// IP-to-MAC cache and pending resolution table held in two RAMs.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// req       in         req_valid, req_ready, req
// rsp       out        rsp_valid, rsp_ready, rsp
// cfg       in (APB)   psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Each RAM has one read port, so entries are read and compared one at a time.
// Valid bits live in flops, so reset needs no clearing pass.
// A new request beat is taken while the last response beat still waits.
// ----------------------------------------------------------------------------
`include "arp_cache_resolver_macros.svh"

module arp_cache_resolver import arpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_beat_t             req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_beat_t             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_P_RD   = 4'd1;
  localparam logic [3:0] S_P_CMP  = 4'd2;
  localparam logic [3:0] S_C_RD   = 4'd3;
  localparam logic [3:0] S_C_CMP  = 4'd4;
  localparam logic [3:0] S_T_PRD  = 4'd5;
  localparam logic [3:0] S_T_PCMP = 4'd6;
  localparam logic [3:0] S_T_CRD  = 4'd7;
  localparam logic [3:0] S_T_CCMP = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  localparam logic [CIDX_W-1:0] C_LAST = CIDX_W'(CACHE_DEPTH - 1);
  localparam logic [PIDX_W-1:0] P_LAST = PIDX_W'(PENDING_DEPTH - 1);

  cfg_t cfg;

  logic [3:0] state, state_next;
  logic [1:0] op, op_next;
  logic [31:0] ip, ip_next;
  logic [47:0] mac, mac_next;
  logic [PORT_BITS-1:0] port, port_next;
  logic [CIDX_W-1:0] cidx, cidx_next;
  logic [PIDX_W-1:0] pidx, pidx_next;
  logic [CACHE_DEPTH-1:0] cvalid, cvalid_next;
  logic [PENDING_DEPTH-1:0] pvalid, pvalid_next;
  logic [31:0] now_ticks, now_ticks_next;
  rsp_beat_t hold, hold_next;
  logic hold_valid, hold_valid_next;
  rsp_beat_t rsp_next;
  logic rsp_valid_next;
  logic [PIDX_W-1:0] pslot, pslot_next;
  logic [PORT_BITS-1:0] pport, pport_next;
  logic [31:0] best_age, best_age_next;
  logic [CIDX_W-1:0] best_idx, best_idx_next;

  logic cwe, pwe;
  logic [CIDX_W-1:0] cwaddr;
  logic [PIDX_W-1:0] pwaddr;
  cache_entry_t cwdata, crd;
  pend_entry_t pwdata_e, prd;

  logic out_free, rsp_load;
  logic [31:0] c_age, p_age;
  logic c_hit, p_hit, p_due;
  logic c_any_free, p_any_free;
  logic [CIDX_W-1:0] c_free_idx, cand_idx, learn_slot;
  logic [PIDX_W-1:0] p_free_idx;
  logic cand_take;

  function automatic rsp_beat_t mk_beat(logic [2:0] kind, logic hit, logic [31:0] a,
                                        logic [47:0] m, logic [3:0] p);
    rsp_beat_t b;
    b.kind     = kind;
    b.hit      = hit;
    b.out_ip   = a;
    b.out_mac  = m;
    b.out_port = p;
    b.last     = 1'b0;
    return b;
  endfunction

  arpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  arpc_ram #(.WIDTH($bits(cache_entry_t)), .DEPTH(CACHE_DEPTH)) u_cache_ram (
    .clk   (clk),
    .we    (cwe),
    .waddr (cwaddr),
    .wdata (cwdata),
    .raddr (cidx),
    .rdata (crd)
  );

  arpc_ram #(.WIDTH($bits(pend_entry_t)), .DEPTH(PENDING_DEPTH)) u_pend_ram (
    .clk   (clk),
    .we    (pwe),
    .waddr (pwaddr),
    .wdata (pwdata_e),
    .raddr (pidx),
    .rdata (prd)
  );

  assign pready    = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  assign c_age = now_ticks - crd.stamp;
  assign p_age = now_ticks - prd.stamp;
  assign c_hit = cvalid[cidx] && (crd.ip == ip);
  assign p_hit = pvalid[pidx] && (prd.ip == ip);
  assign p_due = pvalid[pidx] && (p_age >= {1'b0, cfg.resend_interval_ticks});

  assign cand_take  = (cidx == '0) || (c_age > best_age);
  assign cand_idx   = cand_take ? cidx : best_idx;
  assign learn_slot = c_hit ? cidx : (c_any_free ? c_free_idx : cand_idx);

  always_comb begin
    c_any_free = 1'b0;
    c_free_idx = '0;
    for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
      if (!cvalid[i]) begin
        c_any_free = 1'b1;
        c_free_idx = CIDX_W'(i);
      end
    end
  end

  always_comb begin
    p_any_free = 1'b0;
    p_free_idx = '0;
    for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
      if (!pvalid[i]) begin
        p_any_free = 1'b1;
        p_free_idx = PIDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    ip_next         = ip;
    mac_next        = mac;
    port_next       = port;
    cidx_next       = cidx;
    pidx_next       = pidx;
    cvalid_next     = cvalid;
    pvalid_next     = pvalid;
    now_ticks_next  = now_ticks;
    hold_next       = hold;
    hold_valid_next = hold_valid;
    pslot_next      = pslot;
    pport_next      = pport;
    best_age_next   = best_age;
    best_idx_next   = best_idx;
    cwe             = 1'b0;
    cwaddr          = learn_slot;
    cwdata          = '{ip: ip, mac: mac, stamp: now_ticks};
    pwe             = 1'b0;
    pwaddr          = pidx;
    pwdata_e        = '{ip: prd.ip, port: prd.port, attempts: prd.attempts + 4'd1,
                        stamp: now_ticks};
    rsp_load        = 1'b0;
    rsp_next        = hold;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next         = req.operation;
          ip_next         = req.ip_address;
          mac_next        = req.hw_address;
          port_next       = req.port[PORT_BITS-1:0];
          cidx_next       = '0;
          pidx_next       = '0;
          hold_valid_next = 1'b0;
          best_age_next   = '0;
          best_idx_next   = '0;
          case (req.operation)
            OP_LOOKUP: state_next = S_C_RD;
            OP_TICK: begin
              now_ticks_next = now_ticks + 32'd1;
              state_next     = S_T_PRD;
            end
            default: state_next = S_P_RD;
          endcase
        end
      end
      S_P_RD: state_next = S_P_CMP;
      S_P_CMP: begin
        if (p_hit) begin
          pslot_next = pidx;
          pport_next = prd.port;
          if (op == OP_REPLY) begin
            cidx_next  = '0;
            state_next = S_C_RD;
          end else begin
            hold_next       = mk_beat(KIND_QUEUED, 1'b0, ip, 48'd0, 4'd0);
            hold_valid_next = 1'b1;
            state_next      = S_FIN;
          end
        end else if (pidx == P_LAST) begin
          hold_valid_next = 1'b1;
          state_next      = S_FIN;
          if (op == OP_REPLY) begin
            hold_next = mk_beat(KIND_IGNORED, 1'b0, ip, 48'd0, 4'd0);
          end else if (p_any_free) begin
            pwe                     = 1'b1;
            pwaddr                  = p_free_idx;
            pwdata_e                = '{ip: ip, port: port, attempts: 4'd1, stamp: now_ticks};
            pvalid_next[p_free_idx] = 1'b1;
            hold_next = mk_beat(KIND_SEND_REQ, 1'b0, ip, 48'd0, 4'(port));
          end else begin
            hold_next = mk_beat(KIND_PEND_FULL, 1'b0, ip, 48'd0, 4'd0);
          end
        end else begin
          pidx_next  = pidx + 1'b1;
          state_next = S_P_RD;
        end
      end
      S_C_RD: state_next = S_C_CMP;
      S_C_CMP: begin
        if (op == OP_LOOKUP) begin
          if (c_hit) begin
            hold_next       = mk_beat(KIND_LOOKUP, 1'b1, ip, crd.mac, 4'd0);
            hold_valid_next = 1'b1;
            state_next      = S_FIN;
          end else if (cidx == C_LAST) begin
            hold_next       = mk_beat(KIND_LOOKUP, 1'b0, ip, 48'd0, 4'd0);
            hold_valid_next = 1'b1;
            state_next      = S_FIN;
          end else begin
            cidx_next  = cidx + 1'b1;
            state_next = S_C_RD;
          end
        end else begin
          if (cand_take) begin
            best_age_next = c_age;
            best_idx_next = cidx;
          end
          if (c_hit || cidx == C_LAST) begin
            cwe                     = 1'b1;
            cvalid_next[learn_slot] = 1'b1;
            pvalid_next[pslot]      = 1'b0;
            hold_next       = mk_beat(KIND_FLUSH, 1'b0, ip, mac, 4'(pport));
            hold_valid_next = 1'b1;
            state_next      = S_FIN;
          end else begin
            cidx_next  = cidx + 1'b1;
            state_next = S_C_RD;
          end
        end
      end
      S_T_PRD: state_next = S_T_PCMP;
      S_T_PCMP: begin
        if (!(p_due && hold_valid && !out_free)) begin
          if (p_due) begin
            if (hold_valid) begin
              rsp_load = 1'b1;
            end
            hold_valid_next = 1'b1;
            if (prd.attempts >= cfg.max_attempts) begin
              pvalid_next[pidx] = 1'b0;
              hold_next = mk_beat(KIND_UNREACHABLE, 1'b0, prd.ip, 48'd0, 4'(prd.port));
            end else begin
              pwe       = 1'b1;
              hold_next = mk_beat(KIND_SEND_REQ, 1'b0, prd.ip, 48'd0, 4'(prd.port));
            end
          end
          if (pidx == P_LAST) begin
            cidx_next  = '0;
            state_next = S_T_CRD;
          end else begin
            pidx_next  = pidx + 1'b1;
            state_next = S_T_PRD;
          end
        end
      end
      S_T_CRD: state_next = S_T_CCMP;
      S_T_CCMP: begin
        if (cvalid[cidx] && c_age >= {1'b0, cfg.entry_timeout_ticks}) begin
          cvalid_next[cidx] = 1'b0;
        end
        if (cidx == C_LAST) begin
          state_next = S_FIN;
        end else begin
          cidx_next  = cidx + 1'b1;
          state_next = S_T_CRD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          rsp_load = 1'b1;
          if (hold_valid) begin
            rsp_next = hold;
          end else begin
            rsp_next = mk_beat(KIND_TICK_DONE, 1'b0, 32'd0, 48'd0, 4'd0);
          end
          rsp_next.last   = 1'b1;
          hold_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    rsp_valid_next = rsp_valid && !rsp_ready;
    if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cvalid     <= '0;
      pvalid     <= '0;
      now_ticks  <= '0;
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cvalid     <= cvalid_next;
      pvalid     <= pvalid_next;
      now_ticks  <= now_ticks_next;
      hold_valid <= hold_valid_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    ip       <= ip_next;
    mac      <= mac_next;
    port     <= port_next;
    cidx     <= cidx_next;
    pidx     <= pidx_next;
    hold     <= hold_next;
    pslot    <= pslot_next;
    pport    <= pport_next;
    best_age <= best_age_next;
    best_idx <= best_idx_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  `ARPC_ASSERT_HOLDS(a_idle_no_hold, clk, rst, (state != S_IDLE) || !hold_valid, "result left held in idle")
  `ARPC_ASSERT_HOLDS(a_load_when_free, clk, rst, !rsp_load || out_free, "response beat overwritten")
  `ARPC_ASSERT_NEXT(a_tick_advances, clk, rst, req_valid && req_ready && (req.operation == OP_TICK), now_ticks == $past(now_ticks) + 32'd1, "tick did not advance time")

endmodule
